// ----- src/ndw_pkg.sv -----
`timescale 1ns / 1ps
package ndw_pkg;

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 2;
  localparam int DEPTH_W = 20;
  localparam int ANG_W   = 12;
  localparam int SPD_W   = 16;
  localparam int INT_W   = 20;
  localparam int MILLI_W = 10;
  localparam int MSPD_W  = 30;
  localparam int FLD_W   = 3;
  localparam int MIN_LEN = 6;

  // fixed-point reciprocal divide: q = (m * K) >> QSH, exact for clamped m
  localparam int MW  = 27;
  localparam int KW  = 31;
  localparam int QSH = 36;
  localparam int PW  = MW + KW;
  localparam int QW  = PW - QSH;

  localparam longint unsigned KL_C100 = ((64'd1 << QSH) + 64'd99) / 64'd100;
  localparam longint unsigned KL_KMH  = ((64'd5 << QSH) + 64'd925) / 64'd926;
  localparam longint unsigned KL_MS   = ((64'd243 << QSH) + 64'd12499) / 64'd12500;
  localparam logic [KW-1:0] K_C100 = KW'(KL_C100);
  localparam logic [KW-1:0] K_KMH  = KW'(KL_KMH);
  localparam logic [KW-1:0] K_MS   = KW'(KL_MS);

  localparam logic [INT_W-1:0]   INT_SAT   = 20'hFFFFF;
  localparam logic [ANG_W-1:0]   ANG_SAT   = 12'hFFF;
  localparam logic [DEPTH_W-1:0] DEPTH_SAT = 20'hFFFFF;
  localparam logic [SPD_W-1:0]   SPD_SAT   = 16'hFFFF;

  // sentence type
  localparam logic [1:0] TY_PEND = 2'd0;
  localparam logic [1:0] TY_DBT  = 2'd1;
  localparam logic [1:0] TY_MWV  = 2'd2;
  localparam logic [1:0] TY_BAD  = 2'd3;

  // number flags
  localparam int FB_ACT = 0;
  localparam int FB_NEG = 1;
  localparam int FB_PNT = 2;
  localparam logic [2:0] FL_NONE   = 3'b000;
  localparam logic [2:0] FL_ACTIVE = 3'b001;
  localparam logic [2:0] FL_STAR   = 3'b010;

  // field numbers
  localparam logic [FLD_W-1:0] FLD_NONE   = 3'd0;
  localparam logic [FLD_W-1:0] FLD_ANGLE  = 3'd1;
  localparam logic [FLD_W-1:0] FLD_REF    = 3'd2;
  localparam logic [FLD_W-1:0] FLD_SPEED  = 3'd3;
  localparam logic [FLD_W-1:0] FLD_UNITS  = 3'd4;
  localparam logic [FLD_W-1:0] FLD_STATUS = 3'd5;
  localparam logic [FLD_W-1:0] FLD_LAST   = 3'd7;

  // result kind
  localparam logic [KIND_W-1:0] KIND_DEPTH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRUE  = 2'd2;

  // divider select
  localparam logic [1:0] DS_C100 = 2'd0;
  localparam logic [1:0] DS_KMH  = 2'd1;
  localparam logic [1:0] DS_MS   = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
  localparam logic [CHAR_W-1:0] CH_B      = 8'h42;
  localparam logic [CHAR_W-1:0] CH_D      = 8'h44;
  localparam logic [CHAR_W-1:0] CH_K      = 8'h4B;
  localparam logic [CHAR_W-1:0] CH_M      = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_R      = 8'h52;
  localparam logic [CHAR_W-1:0] CH_T      = 8'h54;
  localparam logic [CHAR_W-1:0] CH_V      = 8'h56;
  localparam logic [CHAR_W-1:0] CH_W      = 8'h57;
  localparam logic [CHAR_W-1:0] CH_LK     = 8'h6B;
  localparam logic [CHAR_W-1:0] CH_LM     = 8'h6D;

endpackage

// ----- src/ndw_in_if.sv -----
`timescale 1ns / 1ps
interface ndw_in_if;
  import ndw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink (input valid, input char_in, input last_char, output ready);
endinterface

// ----- src/ndw_out_if.sv -----
`timescale 1ns / 1ps
interface ndw_out_if;
  import ndw_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [DEPTH_W-1:0] depth_tenths_m;
  logic [ANG_W-1:0]   wind_angle_deg;
  logic [SPD_W-1:0]   wind_speed_tenths_kn;

  modport source (output valid, output result_kind, output depth_tenths_m,
                  output wind_angle_deg, output wind_speed_tenths_kn, input ready);
  modport sink (input valid, input result_kind, input depth_tenths_m,
                input wind_angle_deg, input wind_speed_tenths_kn, output ready);
endinterface

// ----- src/nmea_depth_wind_parser.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake        Payload
// in_bus    in   valid / ready    char_in[7:0], last_char
// out_bus   out  valid / ready    result_kind[1:0], depth_tenths_m[19:0],
//                                 wind_angle_deg[11:0], wind_speed_tenths_kn[15:0]
//
// One byte per cycle while in_bus.ready is high. A request on the final byte passes the
// clamp stage, 27x31 reciprocal multiply and saturate stage before it shows on out_bus.
// Reset is synchronous on rst_n and clears the parser and all valid bits.
// The four result registers collapse bubbles; in_bus.ready drops only while all
// of them hold results and out_bus is stalled.
module nmea_depth_wind_parser #(
  parameter int MAX_SENTENCE_LEN = 100
) (
  input logic       clk,
  input logic       rst_n,
  ndw_in_if.sink    in_bus,
  ndw_out_if.source out_bus
);
  import ndw_pkg::*;

  localparam int PosW = $clog2(MAX_SENTENCE_LEN + 1);
  localparam logic [PosW-1:0] PosMax  = PosW'(MAX_SENTENCE_LEN);
  localparam logic [PosW-1:0] PosMin  = PosW'(MIN_LEN);
  localparam logic [PosW-1:0] PosOne  = PosW'(1);
  localparam logic [PosW-1:0] PosTyA  = PosW'(3);
  localparam logic [PosW-1:0] PosTyB  = PosW'(4);
  localparam logic [PosW-1:0] PosTyC  = PosW'(5);

  typedef struct packed {
    logic [2:0]         flg;
    logic [ANG_W-1:0]   ang;
    logic [MSPD_W-1:0]  spd;
  } fin_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [1:0]         dsel;
    logic [ANG_W-1:0]   ang;
    logic               usep;
    logic               neg;
    logic [INT_W-1:0]   ip;
    logic [MILLI_W-1:0] mp;
    logic [MSPD_W-1:0]  spd;
  } rec_t;

  function automatic logic [ANG_W-1:0] ang_sat(input logic [INT_W-1:0] ip);
    return (ip > INT_W'(ANG_SAT)) ? ANG_SAT : ip[ANG_W-1:0];
  endfunction

  function automatic logic [MSPD_W-1:0] spd_of(input logic [INT_W-1:0] ip,
                                               input logic [MILLI_W-1:0] mp);
    return (MSPD_W'(ip) * MSPD_W'(1000)) + MSPD_W'(mp);
  endfunction

  function automatic fin_t num_fin(input logic [2:0] f, input logic [FLD_W-1:0] fld,
                                   input logic [INT_W-1:0] ip,
                                   input logic [MILLI_W-1:0] mp,
                                   input logic [ANG_W-1:0] ang,
                                   input logic [MSPD_W-1:0] spd);
    fin_t r;
    r.flg = f;
    r.ang = ang;
    r.spd = spd;
    if (f[FB_ACT]) begin
      r.flg = FL_NONE;
      if (fld == FLD_ANGLE) begin
        r.ang = f[FB_NEG] ? '0 : ang_sat(ip);
      end else begin
        r.spd = f[FB_NEG] ? '0 : spd_of(ip, mp);
      end
    end
    return r;
  endfunction

  function automatic logic [MILLI_W-1:0] frac_f(input logic [1:0] n, input logic [3:0] d);
    logic [MILLI_W-1:0] r;
    case (n)
      2'd0:    r = MILLI_W'(d) * MILLI_W'(100);
      2'd1:    r = MILLI_W'(d) * MILLI_W'(10);
      default: r = MILLI_W'(d);
    endcase
    return r;
  endfunction

  // parser state
  logic [PosW-1:0]    pos_r,  pos_nxt;
  logic [1:0]         typ_r,  typ_nxt;
  logic [FLD_W-1:0]   fld_r,  fld_nxt;
  logic               fst_r,  fst_nxt;
  logic [INT_W-1:0]   ip_r,   ip_nxt;
  logic [MILLI_W-1:0] mp_r,   mp_nxt;
  logic [1:0]         fcn_r,  fcn_nxt;
  logic [2:0]         flg_r,  flg_nxt;
  logic [ANG_W-1:0]   ang_r,  ang_nxt;
  logic [MSPD_W-1:0]  spd_r,  spd_nxt;
  logic               refr_r, refr_nxt;
  logic [1:0]         ucl_r,  ucl_nxt;
  logic               sta_r,  sta_nxt;

  logic [CHAR_W-1:0]  c;
  logic [3:0]         d;
  logic               dig;
  logic               go;
  logic               frst;
  logic               stp;
  logic [INT_W+3:0]   iv;
  fin_t               nf;
  logic               res_dep;
  logic               res_wnd;
  logic               rec_ok;
  rec_t               rec_nxt;

  // pipeline
  logic               v1_r, v2_r, v3_r, ov_r;
  logic               rdy1, rdy2, rdy3, rdy_o;
  logic               acc;
  rec_t               rec_r;
  logic [MSPD_W-1:0]  m30;
  logic [MW-1:0]      m_nxt;
  logic [MW-1:0]      m2_r;
  logic [1:0]         ds2_r;
  logic [KIND_W-1:0]  kind2_r, kind3_r;
  logic [ANG_W-1:0]   ang2_r,  ang3_r;
  logic [KW-1:0]      kv;
  logic [PW-1:0]      prod;
  logic [QW-1:0]      q3_r;
  logic [KIND_W-1:0]  okind_r;
  logic [DEPTH_W-1:0] odep_r, odep_nxt;
  logic [ANG_W-1:0]   oang_r, oang_nxt;
  logic [SPD_W-1:0]   ospd_r, ospd_nxt;

  assign rdy_o = !ov_r || out_bus.ready;
  assign rdy3  = !v3_r || rdy_o;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign acc   = in_bus.valid && rdy1;
  assign in_bus.ready = rdy1;

  always_comb begin
    pos_nxt  = pos_r;
    typ_nxt  = typ_r;
    fld_nxt  = fld_r;
    fst_nxt  = fst_r;
    ip_nxt   = ip_r;
    mp_nxt   = mp_r;
    fcn_nxt  = fcn_r;
    flg_nxt  = flg_r;
    ang_nxt  = ang_r;
    spd_nxt  = spd_r;
    refr_nxt = refr_r;
    ucl_nxt  = ucl_r;
    sta_nxt  = sta_r;
    c        = in_bus.char_in;
    d        = c[3:0];
    dig      = (c >= CH_ZERO) && (c <= CH_NINE);
    go       = (pos_r < PosMax) && (typ_r != TY_BAD);
    frst     = 1'b0;
    stp      = 1'b0;
    iv       = '0;
    nf       = '0;
    if (go) begin
      if (c == CH_NUL) begin
        if (pos_r < PosMin) begin
          typ_nxt = TY_BAD;
        end
        nf      = num_fin(flg_nxt, fld_nxt, ip_nxt, mp_nxt, ang_nxt, spd_nxt);
        flg_nxt = nf.flg;
        ang_nxt = nf.ang;
        spd_nxt = nf.spd;
        pos_nxt = PosMax;
      end else if (pos_r == '0) begin
        if (c != CH_DOLLAR) begin
          typ_nxt = TY_BAD;
        end
        pos_nxt = PosOne;
      end else begin
        if (pos_r == PosTyA) begin
          if (c == CH_D) begin
            typ_nxt = TY_DBT;
          end else if (c == CH_M) begin
            typ_nxt = TY_MWV;
          end else begin
            typ_nxt = TY_BAD;
          end
        end else if (pos_r == PosTyB && c != ((typ_nxt == TY_DBT) ? CH_B : CH_W)) begin
          typ_nxt = TY_BAD;
        end else if (pos_r == PosTyC && c != ((typ_nxt == TY_DBT) ? CH_T : CH_V)) begin
          typ_nxt = TY_BAD;
        end
        if (typ_nxt != TY_BAD) begin
          frst = fst_r;
          if (frst) begin
            fst_nxt = 1'b0;
            case (fld_nxt)
              FLD_ANGLE, FLD_SPEED: begin
                ip_nxt  = '0;
                mp_nxt  = '0;
                fcn_nxt = '0;
                flg_nxt = FL_ACTIVE;
                if (fld_nxt == FLD_SPEED && typ_nxt == TY_DBT && c != CH_COMMA) begin
                  fld_nxt = FLD_UNITS;
                end
              end
              FLD_REF: refr_nxt = (c == CH_R);
              FLD_UNITS: begin
                if (c == CH_K || c == CH_LK) begin
                  ucl_nxt = DS_KMH;
                end else if (c == CH_M || c == CH_LM) begin
                  ucl_nxt = DS_MS;
                end else begin
                  ucl_nxt = DS_C100;
                end
              end
              FLD_STATUS: sta_nxt = (c == CH_A);
              default: ;
            endcase
          end
          if (flg_nxt[FB_ACT]) begin
            if (frst && (c == CH_PLUS || c == CH_MINUS)) begin
              if (c == CH_MINUS) begin
                flg_nxt[FB_NEG] = 1'b1;
              end
            end else if (dig) begin
              if (!flg_nxt[FB_PNT]) begin
                iv = {1'b0, ip_nxt, 3'b000} + {3'b000, ip_nxt, 1'b0} + {20'd0, d};
                ip_nxt = (iv > (INT_W + 4)'(INT_SAT)) ? INT_SAT : iv[INT_W-1:0];
              end else if (fcn_nxt != 2'd3) begin
                mp_nxt  = mp_nxt + frac_f(fcn_nxt, d);
                fcn_nxt = fcn_nxt + 2'd1;
              end
            end else if (c == CH_DOT && !flg_nxt[FB_PNT]) begin
              flg_nxt[FB_PNT] = 1'b1;
            end else begin
              nf      = num_fin(flg_nxt, fld_nxt, ip_nxt, mp_nxt, ang_nxt, spd_nxt);
              flg_nxt = nf.flg;
              ang_nxt = nf.ang;
              spd_nxt = nf.spd;
            end
          end
          if (c == CH_COMMA) begin
            if (!(typ_nxt == TY_DBT && fld_nxt >= FLD_SPEED)) begin
              if (fld_nxt != FLD_LAST) begin
                fld_nxt = fld_nxt + FLD_W'(1);
              end
              fst_nxt = 1'b1;
            end
          end else if (c == CH_STAR && fld_nxt != FLD_NONE) begin
            if (typ_nxt == TY_MWV && pos_r >= PosTyA) begin
              stp = 1'b1;
            end else if (pos_r < PosTyA) begin
              flg_nxt = FL_STAR;
            end
          end
          if (!stp && pos_r == PosTyC && typ_nxt == TY_MWV && flg_nxt == FL_STAR) begin
            stp = 1'b1;
          end
          pos_nxt = stp ? PosMax : pos_r + PosOne;
        end
      end
    end

    res_dep = (pos_nxt >= PosMin) && (typ_nxt == TY_DBT) && (fld_nxt == FLD_UNITS);
    res_wnd = (pos_nxt >= PosMin) && (typ_nxt == TY_MWV) && sta_nxt;
    rec_ok  = in_bus.last_char && (res_dep || res_wnd);

    rec_nxt.kind = res_dep ? KIND_DEPTH : (refr_nxt ? KIND_APP : KIND_TRUE);
    rec_nxt.dsel = res_dep ? DS_C100 : ucl_nxt;
    rec_nxt.ang  = (flg_nxt[FB_ACT] && fld_nxt == FLD_ANGLE) ?
                   (flg_nxt[FB_NEG] ? '0 : ang_sat(ip_nxt)) : ang_nxt;
    rec_nxt.usep = flg_nxt[FB_ACT] && (fld_nxt != FLD_ANGLE);
    rec_nxt.neg  = flg_nxt[FB_NEG];
    rec_nxt.ip   = ip_nxt;
    rec_nxt.mp   = mp_nxt;
    rec_nxt.spd  = spd_nxt;

    if (in_bus.last_char) begin
      pos_nxt  = '0;
      typ_nxt  = TY_PEND;
      fld_nxt  = FLD_NONE;
      fst_nxt  = 1'b0;
      ip_nxt   = '0;
      mp_nxt   = '0;
      fcn_nxt  = '0;
      flg_nxt  = FL_NONE;
      ang_nxt  = '0;
      spd_nxt  = '0;
      refr_nxt = 1'b1;
      ucl_nxt  = DS_C100;
      sta_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      typ_r  <= TY_PEND;
      fld_r  <= FLD_NONE;
      fst_r  <= 1'b0;
      ip_r   <= '0;
      mp_r   <= '0;
      fcn_r  <= '0;
      flg_r  <= FL_NONE;
      ang_r  <= '0;
      spd_r  <= '0;
      refr_r <= 1'b1;
      ucl_r  <= DS_C100;
      sta_r  <= 1'b0;
    end else if (acc) begin
      pos_r  <= pos_nxt;
      typ_r  <= typ_nxt;
      fld_r  <= fld_nxt;
      fst_r  <= fst_nxt;
      ip_r   <= ip_nxt;
      mp_r   <= mp_nxt;
      fcn_r  <= fcn_nxt;
      flg_r  <= flg_nxt;
      ang_r  <= ang_nxt;
      spd_r  <= spd_nxt;
      refr_r <= refr_nxt;
      ucl_r  <= ucl_nxt;
      sta_r  <= sta_nxt;
    end
  end

  // clamp the milli value to the range where the reciprocal is exact
  always_comb begin
    m30 = rec_r.usep ? (rec_r.neg ? '0 : spd_of(rec_r.ip, rec_r.mp)) : rec_r.spd;
    case (rec_r.dsel)
      DS_KMH:  m_nxt = (|m30[MSPD_W-1:24]) ? MW'(24'hFFFFFF) : MW'(m30[23:0]);
      DS_MS:   m_nxt = (|m30[MSPD_W-1:22]) ? MW'(22'h3FFFFF) : MW'(m30[21:0]);
      default: m_nxt = (|m30[MSPD_W-1:MW]) ? '1 : m30[MW-1:0];
    endcase
  end

  always_comb begin
    case (ds2_r)
      DS_KMH:  kv = K_KMH;
      DS_MS:   kv = K_MS;
      default: kv = K_C100;
    endcase
    prod = {{KW{1'b0}}, m2_r} * {{MW{1'b0}}, kv};
  end

  always_comb begin
    if (kind3_r == KIND_DEPTH) begin
      odep_nxt = (q3_r > QW'(DEPTH_SAT)) ? DEPTH_SAT : q3_r[DEPTH_W-1:0];
      oang_nxt = '0;
      ospd_nxt = '0;
    end else begin
      odep_nxt = '0;
      oang_nxt = ang3_r;
      ospd_nxt = (|q3_r[QW-1:SPD_W]) ? SPD_SAT : q3_r[SPD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= acc && rec_ok;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy_o) begin
        ov_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      rec_r <= rec_nxt;
    end
    if (rdy2) begin
      m2_r    <= m_nxt;
      ds2_r   <= rec_r.dsel;
      kind2_r <= rec_r.kind;
      ang2_r  <= rec_r.ang;
    end
    if (rdy3) begin
      q3_r    <= prod[PW-1:QSH];
      kind3_r <= kind2_r;
      ang3_r  <= ang2_r;
    end
    if (rdy_o) begin
      okind_r <= kind3_r;
      odep_r  <= odep_nxt;
      oang_r  <= oang_nxt;
      ospd_r  <= ospd_nxt;
    end
  end

  assign out_bus.valid                = ov_r;
  assign out_bus.result_kind          = okind_r;
  assign out_bus.depth_tenths_m       = odep_r;
  assign out_bus.wind_angle_deg       = oang_r;
  assign out_bus.wind_speed_tenths_kn = ospd_r;

endmodule
